### sv/ipo_pkg.sv
// Shared types and constants for the image pixel to occupancy converter.
// Used by ipo_front, ipo_fifo, ipo_back and the top level; no dependencies.

package ipo_pkg;

  // Grid and pixel geometry
  localparam int MAX_DIM      = 4096;
  localparam int DIM_W        = 13;
  localparam int COORD_W      = 12;
  localparam int INDEX_W      = 24;
  localparam int NUM_CH       = 4;
  localparam int SUM_W        = 10;
  localparam int NAVG_W       = 3;
  localparam int THR_W        = 16;

  // Decoupling queue
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  // Cell values
  localparam logic [7:0] VAL_OCCUPIED = 8'd100;
  localparam logic [7:0] VAL_FREE     = 8'd0;
  localparam logic [7:0] VAL_UNKNOWN  = 8'd255;
  localparam logic [7:0] VAL_FLAT     = 8'd1;
  localparam logic [7:0] VAL_FULL     = 8'd255;
  localparam int         SCALE_STEPS  = 98;
  localparam int         Q_W          = 7;

  // floor(x / 3) = (x * 683) >> 11 for x below 2048
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;

  // Register reset values
  localparam logic [THR_W-1:0] OCC_THR_RST  = 16'd42598;
  localparam logic [THR_W-1:0] FREE_THR_RST = 16'd12845;

  // Register map, one 32-bit word per register
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MAP_MODE   = 3'd0,
    REG_NEGATE     = 3'd1,
    REG_CHAN_COUNT = 3'd2,
    REG_ALPHA      = 3'd3,
    REG_OCC_THR    = 3'd4,
    REG_FREE_THR   = 3'd5,
    REG_MAP_WIDTH  = 3'd6,
    REG_MAP_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_TRINARY = 2'd0,
    MODE_SCALE   = 2'd1,
    MODE_RAW     = 2'd2,
    MODE_RAW_ALT = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic               negate;
    logic [2:0]         chan_cnt;
    logic               alpha;
    logic [THR_W-1:0]   occ_thr;
    logic [THR_W-1:0]   free_thr;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  // Classified pixel handed from the front to the back
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SUM_W-1:0]   sum;
    logic [NAVG_W-1:0]  navg;
    logic               mid_unknown;
  } item_t;

endpackage

### sv/ipo_front.sv
// Front end: accepts pixels, sums the counted channels and flags unknown cells.
// Depends on ipo_pkg; feeds ipo_fifo.

module ipo_front
  import ipo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] pixel_col_i,
  input  logic [COORD_W-1:0] pixel_row_i,
  input  logic [7:0]         chan0_i,
  input  logic [7:0]         chan1_i,
  input  logic [7:0]         chan2_i,
  input  logic [7:0]         chan3_i,
  input  logic               full_i,
  output logic               push_o,
  output item_t              item_o
);

  logic              valid_q, valid_d;
  item_t             item_q, item_d;
  logic [NAVG_W-1:0] n;
  logic [NAVG_W-1:0] navg;
  logic              transparent;
  logic              load;

  // Clamp the channel count to one through four
  always_comb begin
    case (cfg_i.chan_cnt)
      3'd0, 3'd1: n = 3'd1;
      3'd2:       n = 3'd2;
      3'd3:       n = 3'd3;
      default:    n = 3'd4;
    endcase
  end

  // Drop the alpha channel from the average outside trinary mode
  assign navg = ((cfg_i.mode != MODE_TRINARY) && cfg_i.alpha && (n > 3'd1)) ? n - 3'd1 : n;

  // Last channel byte of a multi-channel pixel acts as alpha
  always_comb begin
    case (n)
      3'd2:    transparent = (chan1_i == 8'd0);
      3'd3:    transparent = (chan2_i == 8'd0);
      3'd4:    transparent = (chan3_i == 8'd0);
      default: transparent = 1'b0;
    endcase
  end

  // Classify the incoming pixel
  always_comb begin
    item_d.col         = pixel_col_i;
    item_d.row         = pixel_row_i;
    item_d.navg        = navg;
    item_d.mid_unknown = (cfg_i.mode == MODE_TRINARY) || transparent;
    item_d.sum         = SUM_W'(chan0_i)
                       + ((navg > 3'd1) ? SUM_W'(chan1_i) : '0)
                       + ((navg > 3'd2) ? SUM_W'(chan2_i) : '0)
                       + ((navg > 3'd3) ? SUM_W'(chan3_i) : '0);
  end

  // Hold the classified pixel until the queue takes it
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && full_i);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule

### sv/ipo_fifo.sv
// Short queue between the front end and the back end.
// Depends on ipo_pkg for the item type and depth.

module ipo_fifo
  import ipo_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  not_empty_o,
  output item_t pop_data_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;

  assign full_o      = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q != FIFO_CW'(FIFO_DEPTH)) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

### sv/ipo_back.sv
// Back end: threshold compare, pipelined scale division and cell index.
// Depends on ipo_pkg; takes items from ipo_fifo and drives the result register.

module ipo_back
  import ipo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [INDEX_W-1:0] cell_index_o,
  output logic [7:0]         cell_value_o
);

  localparam int TN_W  = THR_W + 2;
  localparam int W26   = TN_W + 8;
  localparam int REM_W = W26 + Q_W;

  typedef struct packed {
    logic               is_raw;
    logic               mid_unknown;
    logic               thr_flat;
    logic [COORD_W-1:0] col;
    logic [INDEX_W-1:0] hrow;
    logic [SUM_W-1:0]   num;
    logic [7:0]         raw_val;
    logic [TN_W-1:0]    occ_tn;
    logic [TN_W-1:0]    free_tn;
    logic [TN_W-1:0]    span_tn;
  } sta_t;

  typedef struct packed {
    logic               is_raw;
    logic               mid_unknown;
    logic               thr_flat;
    logic [COORD_W-1:0] col;
    logic [7:0]         raw_val;
    logic [W26-1:0]     lhs;
    logic [W26-1:0]     occ_rhs;
    logic [W26-1:0]     free_rhs;
    logic [W26-1:0]     span;
    logic [INDEX_W-1:0] prod;
  } stb_t;

  typedef struct packed {
    logic               use_q;
    logic [7:0]         value;
    logic [W26-1:0]     diff;
    logic [W26-1:0]     span;
    logic [INDEX_W-1:0] idx;
  } stc_t;

  typedef struct packed {
    logic               use_q;
    logic [7:0]         value;
    logic [REM_W-1:0]   rem;
    logic [W26-1:0]     span;
    logic [Q_W-1:0]     q;
    logic [INDEX_W-1:0] idx;
  } divst_t;

  function automatic logic [TN_W-1:0] mul_navg(logic [THR_W-1:0] t, logic [NAVG_W-1:0] k);
    logic [TN_W-1:0] r;
    case (k)
      3'd2:    r = TN_W'(t) << 1;
      3'd3:    r = (TN_W'(t) << 1) + TN_W'(t);
      3'd4:    r = TN_W'(t) << 2;
      default: r = TN_W'(t);
    endcase
    return r;
  endfunction

  function automatic logic [W26-1:0] times255(logic [TN_W-1:0] x);
    return {x, 8'd0} - W26'(x);
  endfunction

  logic           adv;
  logic           a_vld_q, b_vld_q, c_vld_q;
  sta_t           a_q, a_d;
  stb_t           b_q, b_d;
  stc_t           c_q, c_d;
  divst_t         div_q [Q_W+1];
  divst_t         div_d [Q_W+1];
  logic           div_vld_q [Q_W+1];
  logic           out_vld_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [7:0]     out_val_q, out_val_d;

  logic [SUM_W-1:0]    den;
  logic [SUM_W-1:0]    raw_x;
  logic [7:0]          raw_div;
  logic [SUM_W+10-1:0] div3_prod;
  logic [THR_W-1:0]    thr_gap;
  logic [DIM_W+INDEX_W-1:0] prod_full;
  logic                gt_occ, lt_free;

  // Whole back pipeline moves when the result register can take a new cell
  assign adv        = !out_vld_q || out_ready_i;
  assign item_pop_o = adv && item_valid_i;

  // Stage A: denominator, numerator, raw average, threshold products
  assign den       = SUM_W'({item_i.navg, 8'd0} - 11'(item_i.navg));
  assign raw_x     = cfg_i.negate ? item_i.sum + SUM_W'(item_i.navg - 3'd1) : item_i.sum;
  assign div3_prod = (SUM_W+10)'(raw_x) * (SUM_W+10)'(DIV3_MUL);
  assign thr_gap   = cfg_i.occ_thr - cfg_i.free_thr;

  always_comb begin
    case (item_i.navg)
      3'd2:    raw_div = raw_x[8:1];
      3'd3:    raw_div = div3_prod[DIV3_SH +: 8];
      3'd4:    raw_div = raw_x[9:2];
      default: raw_div = raw_x[7:0];
    endcase
  end

  always_comb begin
    a_d.is_raw      = (cfg_i.mode == MODE_RAW) || (cfg_i.mode == MODE_RAW_ALT);
    a_d.mid_unknown = item_i.mid_unknown;
    a_d.thr_flat    = (cfg_i.occ_thr <= cfg_i.free_thr);
    a_d.col         = item_i.col;
    a_d.hrow        = INDEX_W'(cfg_i.height) - INDEX_W'(item_i.row) - INDEX_W'(1);
    a_d.num         = cfg_i.negate ? item_i.sum : den - item_i.sum;
    a_d.raw_val     = cfg_i.negate ? VAL_FULL - raw_div : raw_div;
    a_d.occ_tn      = mul_navg(cfg_i.occ_thr, item_i.navg);
    a_d.free_tn     = mul_navg(cfg_i.free_thr, item_i.navg);
    a_d.span_tn     = mul_navg(thr_gap, item_i.navg);
  end

  // Stage B: scale to Q0.16 products and the row offset
  assign prod_full = a_q.hrow * cfg_i.width;

  always_comb begin
    b_d.is_raw      = a_q.is_raw;
    b_d.mid_unknown = a_q.mid_unknown;
    b_d.thr_flat    = a_q.thr_flat;
    b_d.col         = a_q.col;
    b_d.raw_val     = a_q.raw_val;
    b_d.lhs         = {a_q.num, 16'd0};
    b_d.occ_rhs     = times255(a_q.occ_tn);
    b_d.free_rhs    = times255(a_q.free_tn);
    b_d.span        = times255(a_q.span_tn);
    b_d.prod        = prod_full[INDEX_W-1:0];
  end

  // Stage C: compare against both thresholds and pick the cell class
  assign gt_occ  = (b_q.lhs > b_q.occ_rhs);
  assign lt_free = (b_q.lhs < b_q.free_rhs);

  always_comb begin
    c_d.use_q = 1'b0;
    c_d.diff  = b_q.lhs - b_q.free_rhs;
    c_d.span  = b_q.span;
    c_d.idx   = b_q.prod + INDEX_W'(b_q.col);
    if (b_q.is_raw) begin
      c_d.value = b_q.raw_val;
    end else if (gt_occ) begin
      c_d.value = VAL_OCCUPIED;
    end else if (lt_free) begin
      c_d.value = VAL_FREE;
    end else if (b_q.mid_unknown) begin
      c_d.value = VAL_UNKNOWN;
    end else if (b_q.thr_flat) begin
      c_d.value = VAL_FLAT;
    end else begin
      c_d.value = VAL_FLAT;
      c_d.use_q = 1'b1;
    end
  end

  // Stage D: dividend 98 * diff as shifted adds
  always_comb begin
    div_d[0].use_q = c_q.use_q;
    div_d[0].value = c_q.value;
    div_d[0].span  = c_q.span;
    div_d[0].idx   = c_q.idx;
    div_d[0].q     = '0;
    div_d[0].rem   = (REM_W'(c_q.diff) << 6) + (REM_W'(c_q.diff) << 5)
                   + (REM_W'(c_q.diff) << 1);
  end

  // Restoring divider, one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int BIT = Q_W - 1 - k;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(div_q[k].span) << BIT;
    always_comb begin
      div_d[k+1] = div_q[k];
      if (div_q[k].rem >= trial) begin
        div_d[k+1].rem    = div_q[k].rem - trial;
        div_d[k+1].q[BIT] = 1'b1;
      end
    end
  end

  // Result: scaled cells get one plus the quotient
  assign out_val_d = div_q[Q_W].use_q ? VAL_FLAT + 8'(div_q[Q_W].q) : div_q[Q_W].value;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i <= Q_W; i++) begin
        div_vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_q      <= item_valid_i;
      b_vld_q      <= a_vld_q;
      c_vld_q      <= b_vld_q;
      div_vld_q[0] <= c_vld_q;
      for (int i = 1; i <= Q_W; i++) begin
        div_vld_q[i] <= div_vld_q[i-1];
      end
      out_vld_q    <= div_vld_q[Q_W];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= a_d;
      b_q       <= b_d;
      c_q       <= c_d;
      for (int i = 0; i <= Q_W; i++) begin
        div_q[i] <= div_d[i];
      end
      out_idx_q <= div_q[Q_W].idx;
      out_val_q <= out_val_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cell_index_o = out_idx_q;
  assign cell_value_o = out_val_q;

  a_diff_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q && c_q.use_q |-> (c_q.diff <= c_q.span))
    else $error("scale numerator exceeds span");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[Q_W] && div_q[Q_W].use_q |-> (div_q[Q_W].q <= Q_W'(SCALE_STEPS)))
    else $error("scale quotient beyond range");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && c_vld_q |=> div_vld_q[0])
    else $error("item lost between compare and divider");

endmodule

### sv/image_pixel_to_occupancy.sv
// Image pixel to occupancy converter top level: register port and pipeline wiring.
// Depends on ipo_pkg, ipo_front, ipo_fifo and ipo_back.

// Each pixel on the input stream becomes one occupancy grid cell on the output
// stream, in order, at one pixel per clock while the output is not stalled. A pixel
// passes one front register, the four-entry queue, three compare stages, one
// dividend stage, seven stages of the restoring divider that forms the scale-mode
// fraction (one quotient bit each), and the output register. The queue lets the
// input keep transferring while the output is held, until its four entries fill.
// Registers sit at byte addresses 0x00 to 0x1C; the user must write them only while
// no pixel is in flight, as the block itself does not enforce this.

module image_pixel_to_occupancy
  import ipo_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Pixel stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,  // pixel_col[11:0], pixel_row[23:12],
                                           // chan0[31:24], chan1[39:32],
                                           // chan2[47:40], chan3[55:48]
  // Cell stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // cell_index[23:0], cell_value[31:24]
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t               cfg_q, cfg_d;
  cfg_reg_e           reg_sel;
  logic               cfg_wr;
  logic [DIM_W-1:0]   dim_wr;
  logic               push, full, pop, not_empty;
  item_t              push_item, pop_item;
  logic [INDEX_W-1:0] cell_index;
  logic [7:0]         cell_value;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign dim_wr  = (pwdata[DIM_W-1:0] > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : pwdata[DIM_W-1:0];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_MAP_MODE:   cfg_d.mode     = mode_e'(pwdata[1:0]);
        REG_NEGATE:     cfg_d.negate   = pwdata[0];
        REG_CHAN_COUNT: cfg_d.chan_cnt = pwdata[2:0];
        REG_ALPHA:      cfg_d.alpha    = pwdata[0];
        REG_OCC_THR:    cfg_d.occ_thr  = pwdata[THR_W-1:0];
        REG_FREE_THR:   cfg_d.free_thr = pwdata[THR_W-1:0];
        REG_MAP_WIDTH:  cfg_d.width    = dim_wr;
        REG_MAP_HEIGHT: cfg_d.height   = dim_wr;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_TRINARY;
      cfg_q.negate   <= 1'b0;
      cfg_q.chan_cnt <= 3'd1;
      cfg_q.alpha    <= 1'b0;
      cfg_q.occ_thr  <= OCC_THR_RST;
      cfg_q.free_thr <= FREE_THR_RST;
      cfg_q.width    <= DIM_W'(1);
      cfg_q.height   <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_sel)
      REG_MAP_MODE:   prdata = 32'(cfg_q.mode);
      REG_NEGATE:     prdata = 32'(cfg_q.negate);
      REG_CHAN_COUNT: prdata = 32'(cfg_q.chan_cnt);
      REG_ALPHA:      prdata = 32'(cfg_q.alpha);
      REG_OCC_THR:    prdata = 32'(cfg_q.occ_thr);
      REG_FREE_THR:   prdata = 32'(cfg_q.free_thr);
      REG_MAP_WIDTH:  prdata = 32'(cfg_q.width);
      REG_MAP_HEIGHT: prdata = 32'(cfg_q.height);
      default:        prdata = '0;
    endcase
  end

  ipo_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pixel_col_i (s_axis_tdata[11:0]),
    .pixel_row_i (s_axis_tdata[23:12]),
    .chan0_i     (s_axis_tdata[31:24]),
    .chan1_i     (s_axis_tdata[39:32]),
    .chan2_i     (s_axis_tdata[47:40]),
    .chan3_i     (s_axis_tdata[55:48]),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  ipo_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .pop_data_o  (pop_item)
  );

  ipo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (not_empty),
    .item_i       (pop_item),
    .item_pop_o   (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cell_index_o (cell_index),
    .cell_value_o (cell_value)
  );

  assign m_axis_tdata = {cell_value, cell_index};

endmodule

### tb/sv/tb_image_pixel_to_occupancy.sv
// Self-checking testbench for image_pixel_to_occupancy: drives pixels, writes the
// register port between phases and checks every grid cell against a local predictor.
// Depends on ipo_pkg and the image_pixel_to_occupancy top level.
`timescale 1ns / 1ps

module tb_image_pixel_to_occupancy;
  import ipo_pkg::*;

  // Pixel as laid out on s_axis_tdata: col lowest, then row, then chan0..chan3
  typedef struct packed {
    logic [3:0][7:0]    chan;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pixel_t;

  // Cell as laid out on m_axis_tdata: index lowest, value on top
  typedef struct packed {
    logic [7:0]         value;
    logic [INDEX_W-1:0] index;
  } cell_t;

  typedef struct {
    pixel_t px;
    cell_t  want;
  } cell_exp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata = '0;   // pixel_col, pixel_row, chan0..chan3
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // cell_index, cell_value
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Register mirror, reset values
  mode_e       cfg_mode = MODE_TRINARY;
  logic        cfg_negate = 1'b0;
  int unsigned cfg_chans = 1;
  logic        cfg_alpha = 1'b0;
  int unsigned cfg_occ = 32'(OCC_THR_RST);
  int unsigned cfg_free = 32'(FREE_THR_RST);
  int unsigned cfg_width = 1;
  int unsigned cfg_height = 1;

  pixel_t      pixel_q[$];
  cell_exp_t   cell_q[$];
  bit          no_idle = 1'b0;
  int unsigned mismatch_count = 0;

  image_pixel_to_occupancy dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold off with a chance of 12 in a hundred unless a quiet stretch is running
  function automatic bit take_gap();
    return !no_idle && ($urandom_range(0, 99) < 12);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns MISMATCH: %s", $time, msg);
  endtask

  // Occupancy cell that the current register setting yields for one pixel
  function automatic cell_t occupancy_of(pixel_t px);
    int unsigned n, navg, sum, k;
    logic [63:0] den, num, lhs, occ_rhs, free_rhs, span, q, idx;
    logic        transparent;
    logic [7:0]  val;
    cell_t       c;
    n = cfg_chans;
    if (n == 0) n = 1;
    if (n > NUM_CH) n = NUM_CH;
    // alpha drops out of the average outside trinary mode
    navg = n;
    if (cfg_mode != MODE_TRINARY && cfg_alpha && n > 1) navg = n - 1;
    sum = 0;
    for (k = 0; k < navg; k++) sum += 32'(px.chan[k]);
    transparent = (n > 1) && (px.chan[n-1] == 8'd0);
    if (cfg_mode == MODE_RAW || cfg_mode == MODE_RAW_ALT) begin
      if (cfg_negate) val = 8'(255 - (sum + navg - 1) / navg);
      else val = 8'(sum / navg);
    end else begin
      // compare (den - sum) / den, or sum / den when negated, against Q0.16 thresholds exactly
      den      = 64'(255 * navg);
      num      = cfg_negate ? 64'(sum) : den - 64'(sum);
      lhs      = num << 16;
      occ_rhs  = 64'(cfg_occ) * den;
      free_rhs = 64'(cfg_free) * den;
      if (lhs > occ_rhs) val = VAL_OCCUPIED;
      else if (lhs < free_rhs) val = VAL_FREE;
      else if (cfg_mode == MODE_TRINARY || transparent) val = VAL_UNKNOWN;
      else if (cfg_occ <= cfg_free) val = VAL_FLAT;
      else begin
        span = den * 64'(cfg_occ - cfg_free);
        q    = (64'(SCALE_STEPS) * (lhs - free_rhs)) / span;
        val  = 8'(64'd1 + q);
      end
    end
    // flip rows so the origin sits bottom left, wrap to the index width
    idx = 64'(cfg_width) * (64'(cfg_height) - 64'(px.row) - 64'd1) + 64'(px.col);
    c.index = idx[INDEX_W-1:0];
    c.value = val;
    return c;
  endfunction

  // Pixel driver: hold each pixel until its transfer, predict on the transfer
  always @(posedge clk_i) begin
    logic   nxt_valid;
    pixel_t nxt_px;
    cell_exp_t e;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid;
      nxt_px    = pixel_t'(s_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        e.px   = pixel_t'(s_axis_tdata);
        e.want = occupancy_of(e.px);
        cell_q.insert(cell_q.size(), e);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pixel_q.size() != 0 && !take_gap()) begin
        nxt_px    = pixel_q.pop_front();
        nxt_valid = 1'b1;
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_px;
    end
  end

  // Cell monitor: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    cell_t     got;
    cell_exp_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = cell_t'(m_axis_tdata);
        if (cell_q.size() == 0) begin
          report_mismatch($sformatf("unexpected cell index %0d value %0d",
                                    got.index, got.value));
        end else begin
          e = cell_q.pop_front();
          if (got.index !== e.want.index)
            report_mismatch($sformatf("pixel (%0d,%0d) cell_index got %0d want %0d",
                                      e.px.col, e.px.row, got.index, e.want.index));
          if (got.value !== e.want.value)
            report_mismatch($sformatf("pixel (%0d,%0d) ch %h cell_value got %0d want %0d",
                                      e.px.col, e.px.row, e.px.chan, got.value,
                                      e.want.value));
        end
      end
      m_axis_tready <= !take_gap();
    end
  end

  // Register write: setup cycle, then access cycle; mirror the stored value
  task automatic write_reg(input cfg_reg_e r, input logic [31:0] v);
    int unsigned dim;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dim = 32'(v[DIM_W-1:0]);
    if (dim > MAX_DIM) dim = MAX_DIM;
    case (r)
      REG_MAP_MODE:   cfg_mode = mode_e'(v[1:0]);
      REG_NEGATE:     cfg_negate = v[0];
      REG_CHAN_COUNT: cfg_chans = 32'(v[2:0]);
      REG_ALPHA:      cfg_alpha = v[0];
      REG_OCC_THR:    cfg_occ = 32'(v[THR_W-1:0]);
      REG_FREE_THR:   cfg_free = 32'(v[THR_W-1:0]);
      REG_MAP_WIDTH:  cfg_width = dim;
      REG_MAP_HEIGHT: cfg_height = dim;
      default: ;
    endcase
  endtask

  // Write every register; bits above each field carry random junk
  task automatic apply_config(input mode_e mode, input bit neg, input int unsigned chans,
                              input bit alpha, input int unsigned occ,
                              input int unsigned free_thr, input int unsigned w,
                              input int unsigned h);
    write_reg(REG_MAP_MODE,   32'(mode) | ($urandom() << 2));
    write_reg(REG_NEGATE,     32'(neg) | ($urandom() << 1));
    write_reg(REG_CHAN_COUNT, chans | ($urandom() << 3));
    write_reg(REG_ALPHA,      32'(alpha) | ($urandom() << 1));
    write_reg(REG_OCC_THR,    occ | ($urandom() << THR_W));
    write_reg(REG_FREE_THR,   free_thr | ($urandom() << THR_W));
    write_reg(REG_MAP_WIDTH,  w | ($urandom() << DIM_W));
    write_reg(REG_MAP_HEIGHT, h | ($urandom() << DIM_W));
  endtask

  task automatic random_config();
    int unsigned a, b, occ, free_thr, w, h;
    a = $urandom_range(0, 65535);
    b = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0: begin occ = a; free_thr = a; end
      1: begin occ = (a < b) ? a : b; free_thr = (a < b) ? b : a; end
      2: begin occ = 65535; free_thr = 0; end
      default: begin occ = (a < b) ? b : a; free_thr = (a < b) ? a : b; end
    endcase
    case ($urandom_range(0, 7))
      0: begin w = $urandom_range(4097, 8191); h = $urandom_range(0, 8191); end
      1: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
      2: begin w = 4096; h = 4096; end
      default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
    endcase
    apply_config(mode_e'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                 1'($urandom_range(0, 1)), occ, free_thr, w, h);
  endtask

  // Mostly pixels inside the grid, channels biased toward black and white
  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned k, r;
    if (cfg_width != 0 && $urandom_range(0, 3) != 0)
      p.col = COORD_W'($urandom_range(0, cfg_width - 1));
    else p.col = COORD_W'($urandom());
    if (cfg_height != 0 && $urandom_range(0, 3) != 0)
      p.row = COORD_W'($urandom_range(0, cfg_height - 1));
    else p.row = COORD_W'($urandom());
    for (k = 0; k < NUM_CH; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) p.chan[k] = 8'd0;
      else if (r == 1) p.chan[k] = 8'd255;
      else p.chan[k] = 8'($urandom());
    end
    return p;
  endfunction

  // Corner pixels plus one with zero second and fourth channels
  task automatic queue_corner_pixels();
    pixel_t p;
    p.col = '0;
    p.row = '0;
    p.chan = '0;
    pixel_q.insert(pixel_q.size(), p);
    p.col = '1;
    p.row = '1;
    p.chan = '1;
    pixel_q.insert(pixel_q.size(), p);
    p.col = COORD_W'($urandom());
    p.row = COORD_W'($urandom());
    p.chan = {8'd0, 8'($urandom()), 8'd0, 8'($urandom())};
    pixel_q.insert(pixel_q.size(), p);
  endtask

  // Sample at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (pixel_q.size() != 0 || s_axis_tvalid || cell_q.size() != 0) @(negedge clk_i);
  endtask

  // Phase sequencer
  initial begin
    int unsigned ph, k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed settings: reset values first, then the special cases
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        // zero channel count, oversize dimensions, widest thresholds
        1: apply_config(MODE_TRINARY, 1'b0, 0, 1'b1, 65535, 0, 8191, 8191);
        // channel count above four, alpha excluded, negated
        2: apply_config(MODE_SCALE, 1'b1, 7, 1'b1, 40000, 20000, 4096, 4096);
        // alpha with one channel, equal thresholds, zero dimensions
        3: apply_config(MODE_SCALE, 1'b0, 1, 1'b1, 30000, 30000, 0, 0);
        // raw average with negation
        4: apply_config(MODE_RAW, 1'b1, 3, 1'b0, 42598, 12845, 640, 480);
        // mode three acts as raw
        5: apply_config(MODE_RAW_ALT, 1'b0, 4, 1'b1, 0, 65535, 5000, 1);
        // free threshold above occupied threshold
        6: apply_config(MODE_SCALE, 1'b0, 2, 1'b0, 10000, 50000, 1, 4096);
        7: apply_config(MODE_TRINARY, 1'b1, 4, 1'b0, 0, 0, 4095, 4095);
        default: ;
      endcase
      queue_corner_pixels();
      wait_drained();
    end

    // Random settings, two phases without any idling
    for (ph = 0; ph < 16; ph++) begin
      no_idle = (ph == 6 || ph == 7);
      random_config();
      for (k = 0; k < 125; k++) pixel_q.insert(pixel_q.size(), random_pixel());
      wait_drained();
    end
    no_idle = 1'b0;

    // Let the pipeline settle and catch any stray cells
    repeat (40) @(posedge clk_i);
    if (cell_q.size() != 0)
      report_mismatch($sformatf("%0d cells never arrived", cell_q.size()));
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
sv/ipo_pkg.sv
sv/ipo_front.sv
sv/ipo_fifo.sv
sv/ipo_back.sv
sv/image_pixel_to_occupancy.sv
tb/sv/tb_image_pixel_to_occupancy.sv
